/* sv/alm_pkg.sv */
`default_nettype none
package alm_pkg;

   localparam int MAX_ENTRIES = 8;
   localparam int IDX_W       = 3;
   localparam int CNT_W       = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [2:0] CMD_TIME_CHECK  = 3'd0;
   localparam logic [2:0] CMD_TICK        = 3'd1;
   localparam logic [2:0] CMD_ROTATE      = 3'd2;
   localparam logic [2:0] CMD_BUTTON      = 3'd3;
   localparam logic [2:0] CMD_CLICK       = 3'd4;
   localparam logic [2:0] CMD_WRITE_ENTRY = 3'd5;
   localparam logic [2:0] CMD_SET_COUNT   = 3'd6;
   localparam logic [2:0] CMD_ENTER       = 3'd7;

   localparam logic [2:0] BTN_PREV      = 3'd0;
   localparam logic [2:0] BTN_NEXT      = 3'd1;
   localparam logic [2:0] BTN_TOGGLE    = 3'd2;
   localparam logic [2:0] BTN_PREV_LONG = 3'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REPEATS  = 1'd1;

   localparam logic [7:0]       REPEAT_TICKS_RST = 8'd150;
   localparam logic [2:0]       MAX_REPEATS_RST  = 3'd5;
   localparam logic [6:0]       LAST_MIN_NONE    = 7'd127;
   localparam logic [CNT_W-1:0] USED_RST         = CNT_W'(4);
   localparam logic [6:0]       DAYS_EVERY       = 7'h7F;
   localparam logic [6:0]       DAYS_WORK        = 7'h1F;
   localparam logic [2:0]       SUNDAY_BIT       = 3'd6;

   typedef struct packed {
      logic [2:0]        cmd;
      logic              synced;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
      logic [2:0]        weekday;
      logic signed [1:0] delta;
      logic [2:0]        button;
      logic [2:0]        index;
      logic              enable;
      logic [6:0]        days;
      logic [3:0]        count;
   } item_type;

   typedef struct packed {
      logic             toggle;
      logic [IDX_W-1:0] focus_cur;
      logic [IDX_W-1:0] focus_next;
   } tbl_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0] used;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [CNT_W-1:0] active_count;
      logic             focused_on;
   } tbl_stat_type;

   typedef struct packed {
      logic       ringing;
      logic       beep;
      logic       fired;
      logic [2:0] ring_index;
      logic [2:0] focus;
      logic       focused_on;
      logic [3:0] active_count;
      logic       go_back;
      logic       refresh;
   } result_type;

   function automatic logic [CNT_W-1:0] sat_count(input logic [3:0] count);
      sat_count = (count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : count;
   endfunction

   function automatic logic [4:0] init_hour(input int i);
      case (i)
         0: init_hour = 5'd7;
         1: init_hour = 5'd9;
         2: init_hour = 5'd12;
         3: init_hour = 5'd17;
         default: init_hour = 5'd0;
      endcase
   endfunction

   function automatic logic [5:0] init_minute(input int i);
      case (i)
         0: init_minute = 6'd0;
         1: init_minute = 6'd30;
         2: init_minute = 6'd30;
         3: init_minute = 6'd45;
         default: init_minute = 6'd0;
      endcase
   endfunction

   function automatic logic init_enable(input int i);
      case (i)
         0: init_enable = 1'b1;
         1: init_enable = 1'b1;
         3: init_enable = 1'b1;
         default: init_enable = 1'b0;
      endcase
   endfunction

   function automatic logic [6:0] init_days(input int i);
      case (i)
         0: init_days = DAYS_WORK;
         1: init_days = DAYS_WORK;
         2: init_days = DAYS_EVERY;
         3: init_days = DAYS_WORK;
         default: init_days = 7'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

/* sv/alm_table.sv */
`default_nettype none
module alm_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire alm_pkg::item_type     item,
   input  wire alm_pkg::tbl_ctrl_type ctrl,
   output alm_pkg::tbl_stat_type      stat
);

   logic [4:0] hour_ff   [alm_pkg::MAX_ENTRIES];
   logic [4:0] hour_in   [alm_pkg::MAX_ENTRIES];
   logic [5:0] minute_ff [alm_pkg::MAX_ENTRIES];
   logic [5:0] minute_in [alm_pkg::MAX_ENTRIES];
   logic [6:0] days_ff   [alm_pkg::MAX_ENTRIES];
   logic [6:0] days_in   [alm_pkg::MAX_ENTRIES];
   logic [alm_pkg::MAX_ENTRIES-1:0] en_ff;
   logic [alm_pkg::MAX_ENTRIES-1:0] en_in;
   logic [alm_pkg::CNT_W-1:0] used_ff;
   logic [alm_pkg::CNT_W-1:0] used_in;

   logic [2:0]                day_bit;
   logic                      hit;
   logic [alm_pkg::IDX_W-1:0] hit_idx;
   logic [alm_pkg::CNT_W-1:0] active;

   // Monday is bit 0; Sunday and the unused weekday code land on bit 6
   always_comb begin
      if (item.weekday == 3'd0 || item.weekday == 3'd7) begin
         day_bit = alm_pkg::SUNDAY_BIT;
      end else begin
         day_bit = item.weekday - 3'd1;
      end
   end

   // last matching in-use entry wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < alm_pkg::MAX_ENTRIES; i++) begin
         if ((alm_pkg::CNT_W'(i) < used_ff) && en_ff[i]
             && (days_ff[i] == 7'd0 || days_ff[i][day_bit])
             && hour_ff[i] == item.hour && minute_ff[i] == item.minute) begin
            hit     = 1'b1;
            hit_idx = alm_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      hour_in   = hour_ff;
      minute_in = minute_ff;
      days_in   = days_ff;
      en_in     = en_ff;
      used_in   = used_ff;
      if (advance) begin
         if (item.cmd == alm_pkg::CMD_WRITE_ENTRY) begin
            hour_in[item.index]   = item.hour;
            minute_in[item.index] = item.minute;
            days_in[item.index]   = item.days;
            en_in[item.index]     = item.enable;
         end
         if (ctrl.toggle) begin
            en_in[ctrl.focus_cur] = ~en_ff[ctrl.focus_cur];
         end
         if (item.cmd == alm_pkg::CMD_SET_COUNT) begin
            used_in = alm_pkg::sat_count(item.count);
         end
      end
   end

   always_comb begin
      active = '0;
      for (int i = 0; i < alm_pkg::MAX_ENTRIES; i++) begin
         if (alm_pkg::CNT_W'(i) < used_in) begin
            active = active + alm_pkg::CNT_W'(en_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < alm_pkg::MAX_ENTRIES; i++) begin
            hour_ff[i]   <= alm_pkg::init_hour(i);
            minute_ff[i] <= alm_pkg::init_minute(i);
            days_ff[i]   <= alm_pkg::init_days(i);
            en_ff[i]     <= alm_pkg::init_enable(i);
         end
         used_ff <= alm_pkg::USED_RST;
      end else begin
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         days_ff   <= days_in;
         en_ff     <= en_in;
         used_ff   <= used_in;
      end
   end

   assign stat.used         = used_ff;
   assign stat.hit          = hit;
   assign stat.hit_idx      = hit_idx;
   assign stat.active_count = active;
   assign stat.focused_on   = en_in[ctrl.focus_next];

endmodule
`default_nettype wire

/* sv/alm_ctrl.sv */
`default_nettype none
module alm_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire alm_pkg::item_type                   item,
   input  wire alm_pkg::tbl_stat_type               stat,
   input  wire logic                                csr_we,
   input  wire logic [alm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [alm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output alm_pkg::tbl_ctrl_type                    ctrl,
   output alm_pkg::result_type                      result
);

   logic [7:0]                repeat_ticks_ff;
   logic [2:0]                max_repeats_ff;
   logic [alm_pkg::IDX_W-1:0] focus_ff;
   logic [alm_pkg::IDX_W-1:0] focus_in;
   logic                      ring_ff;
   logic                      ring_in;
   logic [7:0]                ticks_ff;
   logic [7:0]                ticks_in;
   logic [2:0]                reps_ff;
   logic [2:0]                reps_in;
   logic [6:0]                last_min_ff;
   logic [6:0]                last_min_in;
   logic [alm_pkg::IDX_W-1:0] fired_ff;
   logic [alm_pkg::IDX_W-1:0] fired_in;

   logic                      beep;
   logic                      fired;
   logic                      go_back;
   logic                      refresh;
   logic                      toggle;
   logic                      has_entries;
   logic [alm_pkg::IDX_W-1:0] focus_up;
   logic [alm_pkg::IDX_W-1:0] focus_down;
   logic [alm_pkg::CNT_W-1:0] new_used;
   logic [8:0]                period;
   logic [8:0]                tick_next;

   assign has_entries = (stat.used != '0);

   // focus stays below the in-use count whenever the table is not empty
   assign focus_up   = ({1'b0, focus_ff} + 4'd1 >= stat.used) ? '0 : focus_ff + 3'd1;
   assign focus_down = (focus_ff == '0) ? alm_pkg::IDX_W'(stat.used - 4'd1)
                                        : focus_ff - 3'd1;

   assign new_used  = alm_pkg::sat_count(item.count);
   assign period    = {(repeat_ticks_ff == 8'd0), repeat_ticks_ff};
   assign tick_next = {1'b0, ticks_ff} + 9'd1;

   always_comb begin
      focus_in    = focus_ff;
      ring_in     = ring_ff;
      ticks_in    = ticks_ff;
      reps_in     = reps_ff;
      last_min_in = last_min_ff;
      fired_in    = fired_ff;
      beep        = 1'b0;
      fired       = 1'b0;
      go_back     = 1'b0;
      refresh     = 1'b0;
      toggle      = 1'b0;
      case (item.cmd)
         alm_pkg::CMD_TIME_CHECK: begin
            if (item.synced && item.second <= 6'd1 && last_min_ff != {1'b0, item.minute}) begin
               last_min_in = {1'b0, item.minute};
               if (stat.hit) begin
                  fired_in = stat.hit_idx;
                  ring_in  = 1'b1;
                  ticks_in = '0;
                  reps_in  = '0;
                  beep     = 1'b1;
                  fired    = 1'b1;
                  refresh  = 1'b1;
               end
            end
         end
         alm_pkg::CMD_TICK: begin
            if (ring_ff) begin
               if (tick_next >= period) begin
                  ticks_in = '0;
                  reps_in  = reps_ff + 3'd1;
                  if (reps_in >= max_repeats_ff) begin
                     ring_in = 1'b0;
                  end else begin
                     beep = 1'b1;
                  end
                  refresh = 1'b1;
               end else begin
                  ticks_in = tick_next[7:0];
               end
            end
         end
         alm_pkg::CMD_ROTATE: begin
            if (has_entries) begin
               if (item.delta == 2'sd1) begin
                  focus_in = focus_up;
               end else if (item.delta != 2'sd0) begin
                  focus_in = focus_down;
               end
            end
            refresh = 1'b1;
         end
         alm_pkg::CMD_BUTTON: begin
            if (ring_ff) begin
               ring_in = 1'b0;
               refresh = 1'b1;
            end else if (item.button == alm_pkg::BTN_PREV_LONG) begin
               go_back = 1'b1;
            end else if (item.button == alm_pkg::BTN_PREV) begin
               if (has_entries) focus_in = focus_down;
               refresh = 1'b1;
            end else if (item.button == alm_pkg::BTN_NEXT) begin
               if (has_entries) focus_in = focus_up;
               refresh = 1'b1;
            end else if (item.button == alm_pkg::BTN_TOGGLE) begin
               toggle  = has_entries;
               refresh = 1'b1;
            end
         end
         alm_pkg::CMD_CLICK: begin
            if (ring_ff) begin
               ring_in = 1'b0;
            end else begin
               toggle = has_entries;
            end
            refresh = 1'b1;
         end
         alm_pkg::CMD_WRITE_ENTRY: begin
         end
         alm_pkg::CMD_SET_COUNT: begin
            if (new_used != '0 && {1'b0, focus_ff} >= new_used) begin
               focus_in = alm_pkg::IDX_W'(new_used - 4'd1);
            end
         end
         default: begin
            focus_in = '0;
            refresh  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ticks_ff <= alm_pkg::REPEAT_TICKS_RST;
         max_repeats_ff  <= alm_pkg::MAX_REPEATS_RST;
      end else if (csr_we) begin
         if (csr_index == alm_pkg::CSR_REPEAT_TICKS) begin
            repeat_ticks_ff <= csr_wdata;
         end
         if (csr_index == alm_pkg::CSR_MAX_REPEATS) begin
            max_repeats_ff <= csr_wdata[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focus_ff    <= '0;
         ring_ff     <= 1'b0;
         ticks_ff    <= '0;
         reps_ff     <= '0;
         last_min_ff <= alm_pkg::LAST_MIN_NONE;
         fired_ff    <= '0;
      end else if (advance) begin
         focus_ff    <= focus_in;
         ring_ff     <= ring_in;
         ticks_ff    <= ticks_in;
         reps_ff     <= reps_in;
         last_min_ff <= last_min_in;
         fired_ff    <= fired_in;
      end
   end

   assign ctrl.toggle     = toggle;
   assign ctrl.focus_cur  = focus_ff;
   assign ctrl.focus_next = focus_in;

   assign result.ringing      = ring_in;
   assign result.beep         = beep;
   assign result.fired        = fired;
   assign result.ring_index   = fired_in;
   assign result.focus        = focus_in;
   assign result.focused_on   = stat.focused_on;
   assign result.active_count = stat.active_count;
   assign result.go_back      = go_back;
   assign result.refresh      = refresh;

endmodule
`default_nettype wire

/* sv/alarm_table_matcher_ringer.sv */
// Flow: an accepted transaction waits in the input register, moves into the result register
//   once that register is free or being drained, and is held there while rsp_stall holds.
// Throughput: one transaction per cycle unless rsp_stall holds; the input and result registers
//   let a new transaction enter while a finished result waits.
// Reset (synchronous, active high): clears both valid flags, restores the default alarm
//   table (four entries in use), focus 0, ringing off, repeat period 150, max repeats 5.
`default_nettype none
module alarm_table_matcher_ringer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [2:0]                        req_cmd,
   input  wire logic                              req_synced,
   input  wire logic [4:0]                        req_hour,
   input  wire logic [5:0]                        req_minute,
   input  wire logic [5:0]                        req_second,
   input  wire logic [2:0]                        req_weekday,
   input  wire logic signed [1:0]                 req_delta,
   input  wire logic [2:0]                        req_button,
   input  wire logic [2:0]                        req_index,
   input  wire logic                              req_enable,
   input  wire logic [6:0]                        req_days,
   input  wire logic [3:0]                        req_count,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_ringing,
   output logic                                   rsp_beep,
   output logic                                   rsp_fired,
   output logic [2:0]                             rsp_ring_index,
   output logic [2:0]                             rsp_focus,
   output logic                                   rsp_focused_on,
   output logic [3:0]                             rsp_active_count,
   output logic                                   rsp_go_back,
   output logic                                   rsp_refresh,
   // configuration
   input  wire logic                              csr_we,
   input  wire logic [alm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [alm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   alm_pkg::item_type     item_ff;
   alm_pkg::item_type     item_in;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   alm_pkg::result_type   rsp_ff;
   alm_pkg::result_type   result;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  advance;
   logic                  accept;
   alm_pkg::tbl_ctrl_type ctrl;
   alm_pkg::tbl_stat_type stat;

   // advance the held transaction when the result register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in.cmd     = req_cmd;
      item_in.synced  = req_synced;
      item_in.hour    = req_hour;
      item_in.minute  = req_minute;
      item_in.second  = req_second;
      item_in.weekday = req_weekday;
      item_in.delta   = req_delta;
      item_in.button  = req_button;
      item_in.index   = req_index;
      item_in.enable  = req_enable;
      item_in.days    = req_days;
      item_in.count   = req_count;
   end

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // hold the result while the consumer stalls, drop it once taken
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   // alarm storage, time matching and enabled-entry count
   alm_table u_table (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .ctrl    (ctrl),
      .stat    (stat)
   );

   // ring sequencing, focus navigation and configuration registers
   alm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item_ff),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .result    (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ringing      = rsp_ff.ringing;
   assign rsp_beep         = rsp_ff.beep;
   assign rsp_fired        = rsp_ff.fired;
   assign rsp_ring_index   = rsp_ff.ring_index;
   assign rsp_focus        = rsp_ff.focus;
   assign rsp_focused_on   = rsp_ff.focused_on;
   assign rsp_active_count = rsp_ff.active_count;
   assign rsp_go_back      = rsp_ff.go_back;
   assign rsp_refresh      = rsp_ff.refresh;

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam int NUM_PHASES    = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int CYCLE_LIMIT   = 400000;

   // ---------------------------------------------------------------------------------------
   // DUT ports; every input starts at a known value
   // ---------------------------------------------------------------------------------------
   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [2:0]                     req_cmd     = '0;
   logic                           req_synced  = '0;
   logic [4:0]                     req_hour    = '0;
   logic [5:0]                     req_minute  = '0;
   logic [5:0]                     req_second  = '0;
   logic [2:0]                     req_weekday = '0;
   logic signed [1:0]              req_delta   = '0;
   logic [2:0]                     req_button  = '0;
   logic [2:0]                     req_index   = '0;
   logic                           req_enable  = '0;
   logic [6:0]                     req_days    = '0;
   logic [3:0]                     req_count   = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_ringing;
   logic                           rsp_beep;
   logic                           rsp_fired;
   logic [2:0]                     rsp_ring_index;
   logic [2:0]                     rsp_focus;
   logic                           rsp_focused_on;
   logic [3:0]                     rsp_active_count;
   logic                           rsp_go_back;
   logic                           rsp_refresh;
   logic                           csr_we    = 1'b0;
   logic [alm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [alm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   alarm_table_matcher_ringer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_synced       (req_synced),
      .req_hour         (req_hour),
      .req_minute       (req_minute),
      .req_second       (req_second),
      .req_weekday      (req_weekday),
      .req_delta        (req_delta),
      .req_button       (req_button),
      .req_index        (req_index),
      .req_enable       (req_enable),
      .req_days         (req_days),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ringing      (rsp_ringing),
      .rsp_beep         (rsp_beep),
      .rsp_fired        (rsp_fired),
      .rsp_ring_index   (rsp_ring_index),
      .rsp_focus        (rsp_focus),
      .rsp_focused_on   (rsp_focused_on),
      .rsp_active_count (rsp_active_count),
      .rsp_go_back      (rsp_go_back),
      .rsp_refresh      (rsp_refresh),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Alarm state mirror: table, focus, ring counters and the two registers
   // ---------------------------------------------------------------------------------------
   logic [4:0]  alm_hour   [alm_pkg::MAX_ENTRIES];
   logic [5:0]  alm_minute [alm_pkg::MAX_ENTRIES];
   logic        alm_on     [alm_pkg::MAX_ENTRIES];
   logic [6:0]  alm_days   [alm_pkg::MAX_ENTRIES];
   int unsigned alm_used;
   logic [2:0]  cur_focus;
   logic        ring_on;
   logic [7:0]  ring_tick_cnt;
   logic [2:0]  ring_rep_cnt;
   logic [6:0]  last_minute;
   logic [2:0]  ring_entry;
   logic [7:0]  period_cfg;
   logic [2:0]  repeat_limit_cfg;

   alm_pkg::result_type pending_status[$];
   int                  fail_count  = 0;
   int                  items_sent  = 0;
   int unsigned         cycle_count = 0;

   typedef struct {
      alm_pkg::item_type   item;
      bit                  typed;
      alm_pkg::result_type want;
   } dir_row_type;

   task automatic load_default_alarms();
      for (int k = 0; k < alm_pkg::MAX_ENTRIES; k++) begin
         alm_hour[k]   = '0;
         alm_minute[k] = '0;
         alm_on[k]     = 1'b0;
         alm_days[k]   = '0;
      end
      // 7:00 and 9:30 on weekdays, 12:30 daily but off, 17:45 on weekdays
      alm_hour[0] = 5'd7;  alm_minute[0] = 6'd0;  alm_on[0] = 1'b1; alm_days[0] = 7'h1F;
      alm_hour[1] = 5'd9;  alm_minute[1] = 6'd30; alm_on[1] = 1'b1; alm_days[1] = 7'h1F;
      alm_hour[2] = 5'd12; alm_minute[2] = 6'd30; alm_on[2] = 1'b0; alm_days[2] = 7'h7F;
      alm_hour[3] = 5'd17; alm_minute[3] = 6'd45; alm_on[3] = 1'b1; alm_days[3] = 7'h1F;
      alm_used         = 4;
      cur_focus        = '0;
      ring_on          = 1'b0;
      ring_tick_cnt    = '0;
      ring_rep_cnt     = '0;
      last_minute      = 7'd127;
      ring_entry       = '0;
      period_cfg       = 8'd150;
      repeat_limit_cfg = 3'd5;
   endtask

   // Wrap the focus around the entries in use; an empty table leaves it alone.
   function automatic void shift_focus(int unsigned add);
      if (alm_used > 0)
         cur_focus = 3'((cur_focus + add) % alm_used);
   endfunction

   function automatic void flip_focused();
      if (alm_used > 0)
         alm_on[cur_focus] = ~alm_on[cur_focus];
   endfunction

   // Advance the mirror by one transaction and return the status it should report.
   function automatic alm_pkg::result_type next_alarm_status(alm_pkg::item_type it);
      alm_pkg::result_type st;
      logic [2:0]          day_bit;
      logic                hit;
      int unsigned         period;
      int unsigned         enabled;
      st = '0;
      case (it.cmd)
         alm_pkg::CMD_TIME_CHECK: begin
            if (it.synced && it.second <= 6'd1 && last_minute != {1'b0, it.minute}) begin
               // Sunday is mask bit 6; weekday seven lands on the same bit
               day_bit     = (it.weekday == 3'd0) ? alm_pkg::SUNDAY_BIT : it.weekday - 3'd1;
               hit         = 1'b0;
               last_minute = {1'b0, it.minute};
               // scan all entries in use; the last match wins
               for (int k = 0; k < alm_used; k++) begin
                  if (alm_on[k] && (alm_days[k] == 7'd0 || alm_days[k][day_bit]) &&
                      alm_hour[k] == it.hour && alm_minute[k] == it.minute) begin
                     hit        = 1'b1;
                     ring_entry = 3'(k);
                  end
               end
               if (hit) begin
                  ring_on       = 1'b1;
                  ring_tick_cnt = '0;
                  ring_rep_cnt  = '0;
                  st.beep       = 1'b1;
                  st.fired      = 1'b1;
                  st.refresh    = 1'b1;
               end
            end
         end
         alm_pkg::CMD_TICK: begin
            if (ring_on) begin
               // a zero period counts as 256 ticks
               period = (period_cfg == 8'd0) ? 256 : period_cfg;
               if (32'(ring_tick_cnt) + 1 >= period) begin
                  ring_tick_cnt = '0;
                  ring_rep_cnt  = ring_rep_cnt + 3'd1;
                  if (ring_rep_cnt >= repeat_limit_cfg)
                     ring_on = 1'b0;
                  else
                     st.beep = 1'b1;
                  st.refresh = 1'b1;
               end else begin
                  ring_tick_cnt = ring_tick_cnt + 8'd1;
               end
            end
         end
         alm_pkg::CMD_ROTATE: begin
            // minus two steps back like minus one; rotating never silences the ring
            if (it.delta == 2'sd1)
               shift_focus(alm_used + 1);
            else if (it.delta != 2'sd0)
               shift_focus(alm_used > 0 ? alm_used - 1 : 0);
            else
               shift_focus(alm_used);
            st.refresh = 1'b1;
         end
         alm_pkg::CMD_BUTTON: begin
            if (ring_on) begin
               ring_on    = 1'b0;
               st.refresh = 1'b1;
            end else if (it.button == alm_pkg::BTN_PREV_LONG) begin
               st.go_back = 1'b1;
            end else if (it.button == alm_pkg::BTN_PREV) begin
               shift_focus(alm_used > 0 ? alm_used - 1 : 0);
               st.refresh = 1'b1;
            end else if (it.button == alm_pkg::BTN_NEXT) begin
               shift_focus(1);
               st.refresh = 1'b1;
            end else if (it.button == alm_pkg::BTN_TOGGLE) begin
               flip_focused();
               st.refresh = 1'b1;
            end
         end
         alm_pkg::CMD_CLICK: begin
            if (ring_on)
               ring_on = 1'b0;
            else
               flip_focused();
            st.refresh = 1'b1;
         end
         alm_pkg::CMD_WRITE_ENTRY: begin
            alm_hour[it.index]   = it.hour;
            alm_minute[it.index] = it.minute;
            alm_on[it.index]     = it.enable;
            alm_days[it.index]   = it.days;
         end
         alm_pkg::CMD_SET_COUNT: begin
            alm_used = (it.count > 4'(alm_pkg::MAX_ENTRIES)) ? alm_pkg::MAX_ENTRIES : it.count;
            if (alm_used > 0 && cur_focus >= alm_used)
               cur_focus = 3'(alm_used - 1);
         end
         alm_pkg::CMD_ENTER: begin
            cur_focus  = '0;
            st.refresh = 1'b1;
         end
         default: ;
      endcase
      enabled = 0;
      for (int k = 0; k < alm_used; k++)
         enabled += alm_on[k];
      st.ringing      = ring_on;
      st.ring_index   = ring_entry;
      st.focus        = cur_focus;
      st.focused_on   = alm_on[cur_focus];
      st.active_count = 4'(enabled);
      return st;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic dir_row_type dir_row(alm_pkg::item_type it, bit typed = 1'b0,
                                           alm_pkg::result_type want = '0);
      dir_row_type rw;
      rw.item  = it;
      rw.typed = typed;
      rw.want  = want;
      return rw;
   endfunction

   // Offer one transaction after an idle gap, hold it until accepted, then queue
   // its status. A typed row keeps its literal status but still advances the mirror.
   task automatic offer_alarm_item(alm_pkg::item_type it, int unsigned gap, bit typed = 1'b0,
                                   alm_pkg::result_type want = '0);
      alm_pkg::result_type due;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= it.cmd;
      req_synced  <= it.synced;
      req_hour    <= it.hour;
      req_minute  <= it.minute;
      req_second  <= it.second;
      req_weekday <= it.weekday;
      req_delta   <= it.delta;
      req_button  <= it.button;
      req_index   <= it.index;
      req_enable  <= it.enable;
      req_days    <= it.days;
      req_count   <= it.count;
      do @(posedge clock); while (req_stall);
      due = next_alarm_status(it);
      pending_status.push_back(typed ? want : due);
      items_sent++;
   endtask

   // Random transaction: all fields random, then shaped toward sequences that
   // actually fire alarms and run the ring counters.
   function automatic alm_pkg::item_type random_alarm_item();
      alm_pkg::item_type it;
      logic [63:0]       raw;
      int unsigned       pick;
      int unsigned       k;
      raw  = {$urandom, $urandom};
      it   = raw[$bits(alm_pkg::item_type)-1:0];
      pick = $urandom_range(0, 99);
      if (ring_on && $urandom_range(0, 1)) begin
         // keep a ringing alarm counting toward its repeats
         it.cmd = alm_pkg::CMD_TICK;
      end else if (pick < 28) begin
         it.cmd    = alm_pkg::CMD_TIME_CHECK;
         it.synced = 1'b1;
         it.second = 6'($urandom_range(0, 1));
         if (alm_used > 0 && $urandom_range(0, 99) < 65) begin
            k         = $urandom_range(0, alm_used - 1);
            it.hour   = alm_hour[k];
            it.minute = alm_minute[k];
         end else begin
            it.hour   = 5'($urandom_range(0, 23));
            it.minute = 6'($urandom_range(0, 59));
         end
      end else if (pick < 38) begin
         it.cmd = alm_pkg::CMD_TIME_CHECK;
      end else if (pick < 55) begin
         it.cmd = alm_pkg::CMD_TICK;
      end else if (pick < 65) begin
         it.cmd = alm_pkg::CMD_ROTATE;
      end else if (pick < 77) begin
         it.cmd = alm_pkg::CMD_BUTTON;
         if ($urandom_range(0, 99) < 85)
            it.button = 3'($urandom_range(0, 3));
      end else if (pick < 83) begin
         it.cmd = alm_pkg::CMD_CLICK;
      end else if (pick < 92) begin
         it.cmd = alm_pkg::CMD_WRITE_ENTRY;
         if ($urandom_range(0, 99) < 80) begin
            it.hour   = 5'($urandom_range(0, 23));
            it.minute = 6'($urandom_range(0, 59));
         end
      end else if (pick < 97) begin
         it.cmd = alm_pkg::CMD_SET_COUNT;
         if ($urandom_range(0, 1))
            it.count = 4'($urandom_range(1, alm_pkg::MAX_ENTRIES));
      end else begin
         it.cmd = alm_pkg::CMD_ENTER;
      end
      return it;
   endfunction

   // Arm entry 0 for a fresh minute, fire it, then feed a run of ticks so that
   // long repeat periods reach their end.
   task automatic ring_out(int unsigned ticks);
      alm_pkg::item_type it;
      logic [5:0]        m;
      m = 6'($urandom_range(0, 59));
      if ({1'b0, m} == last_minute)
         m = (m == 6'd59) ? 6'd0 : m + 6'd1;
      it       = '0;
      it.cmd   = alm_pkg::CMD_SET_COUNT;
      it.count = 4'(alm_pkg::MAX_ENTRIES);
      offer_alarm_item(it, pick_gap());
      it.cmd    = alm_pkg::CMD_WRITE_ENTRY;
      it.index  = '0;
      it.hour   = 5'($urandom_range(0, 23));
      it.minute = m;
      it.enable = 1'b1;
      it.days   = '0;
      offer_alarm_item(it, pick_gap());
      it.cmd     = alm_pkg::CMD_TIME_CHECK;
      it.synced  = 1'b1;
      it.second  = '0;
      it.weekday = 3'($urandom_range(0, 6));
      offer_alarm_item(it, pick_gap());
      it     = '0;
      it.cmd = alm_pkg::CMD_TICK;
      repeat (ticks) offer_alarm_item(it, pick_gap());
   endtask

   // Drop valid and wait until every queued status has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers, one after the other, while the block is idle.
   task automatic write_regs(logic [7:0] period, logic [2:0] limit);
      csr_we    <= 1'b1;
      csr_index <= alm_pkg::CSR_REPEAT_TICKS;
      csr_wdata <= period;
      @(posedge clock);
      period_cfg = period;
      csr_index <= alm_pkg::CSR_MAX_REPEATS;
      csr_wdata <= alm_pkg::CSR_DATA_W'(limit);
      @(posedge clock);
      repeat_limit_cfg = limit;
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence: reset, directed rows, then random phases under several settings
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      dir_row_type rows[$];
      load_default_alarms();

      // After reset: entries 0, 1 and 3 on, focus on entry 0
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_ENTER, default: '0}, 1'b1,
         '{focused_on: 1'b1, active_count: 4'd3, refresh: 1'b1, default: '0}));
      // Long press on prev: go back, no redraw, focus stays
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_BUTTON, button: alm_pkg::BTN_PREV_LONG,
         default: '0}, 1'b1,
         '{focused_on: 1'b1, active_count: 4'd3, go_back: 1'b1, default: '0}));
      // every encoder code, minus two included
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_ROTATE, delta: 2'b01, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_ROTATE, delta: 2'b11, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_ROTATE, delta: 2'b10, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_ROTATE, delta: 2'b00, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_BUTTON, button: alm_pkg::BTN_NEXT,
         default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_BUTTON, button: alm_pkg::BTN_PREV,
         default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_BUTTON, button: alm_pkg::BTN_TOGGLE,
         default: '0}));
      // unused button code changes nothing and asks for no redraw
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_BUTTON, button: 3'd7, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_CLICK, default: '0}));
      // Monday 7:00 fires entry 0; the same minute again stays quiet
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_TIME_CHECK, synced: 1'b1, hour: 5'd7,
         weekday: 3'd1, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_TIME_CHECK, synced: 1'b1, hour: 5'd7,
         second: 6'd1, weekday: 3'd1, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_TICK, default: '0}));
      // any button silences the ring
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_BUTTON, button: alm_pkg::BTN_NEXT,
         default: '0}));
      // two entries at 23:59, one every day, one by mask; fill the table past its size
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_WRITE_ENTRY, index: 3'd7, hour: 5'd23,
         minute: 6'd59, enable: 1'b1, days: 7'h7F, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_WRITE_ENTRY, index: 3'd4, hour: 5'd23,
         minute: 6'd59, enable: 1'b1, days: 7'h00, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_SET_COUNT, count: 4'd15, default: '0}));
      // weekday seven, both match, the last entry latches
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_TIME_CHECK, synced: 1'b1, hour: 5'd23,
         minute: 6'd59, second: 6'd1, weekday: 3'd7, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_ROTATE, delta: 2'b01, default: '0}));
      // not synced, then leap second: neither checks
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_TIME_CHECK, minute: 6'd10, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_TIME_CHECK, synced: 1'b1, minute: 6'd11,
         second: 6'd60, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_CLICK, default: '0}));
      // empty table: moves and toggles only redraw; then clamp focus on regrow
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_SET_COUNT, count: 4'd0, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_BUTTON, button: alm_pkg::BTN_TOGGLE,
         default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_ROTATE, delta: 2'b01, default: '0}));
      rows.push_back(dir_row('{cmd: alm_pkg::CMD_SET_COUNT, count: 4'd2, default: '0}));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         offer_alarm_item(rows[i].item, pick_gap(), rows[i].typed, rows[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         // phase 0 runs on the reset settings
         case (p)
            1: write_regs(8'd1, 3'd1);
            2: write_regs(8'd0, 3'd0);
            3: write_regs(8'd255, 3'd7);
            4: write_regs(8'($urandom_range(2, 12)), 3'($urandom_range(0, 7)));
            5: write_regs(8'($urandom_range(1, 6)), 3'($urandom_range(1, 7)));
            default: ;
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            offer_alarm_item(random_alarm_item(), ((i % 50) < 10) ? 0 : pick_gap());
         // let long periods run out; the second run leaves the ring counted past
         // the short period written next
         if (p == 2) ring_out(260);
         if (p == 3) ring_out(275);
      end

      // drain, then allow the pipeline to go quiet
      req_valid <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && pending_status.size() != 0; w++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_status.size() != 0) begin
         $error("%0d status transactions never arrived", pending_status.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: one long hold so the block backs up, then random stalls
   // ---------------------------------------------------------------------------------------
   initial begin : stall_gen
      int unsigned len;
      wait (items_sent >= 40);
      @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      forever begin
         len = pick_gap();
         if (len == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Checker: compare every accepted status transaction with the oldest queued one
   // ---------------------------------------------------------------------------------------
   function automatic void check_field(string name, logic [3:0] due, logic [3:0] seen);
      if (seen !== due) begin
         $error("%s: expected %0d, got %0d", name, due, seen);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : status_check
      alm_pkg::result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("status transaction arrived with nothing pending");
            fail_count++;
         end else begin
            due = pending_status.pop_front();
            check_field("ringing", due.ringing, rsp_ringing);
            check_field("beep", due.beep, rsp_beep);
            check_field("fired", due.fired, rsp_fired);
            check_field("ring_index", due.ring_index, rsp_ring_index);
            check_field("focus", due.focus, rsp_focus);
            check_field("focused_on", due.focused_on, rsp_focused_on);
            check_field("active_count", due.active_count, rsp_active_count);
            check_field("go_back", due.go_back, rsp_go_back);
            check_field("refresh", due.refresh, rsp_refresh);
         end
      end
   end

   // Watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
